// ===== rtl/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

  localparam int COMPONENT_BITS_DEF = 16;

  // hue sextant, six steps round the colour wheel
  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_t;

endpackage

// ===== rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB pixel converter.
// Input channel: hue, saturation, lightness with in_valid / in_stall. A pixel is
// taken at a rising edge where in_valid is high and in_stall is low.
// Output channel: red, green, blue with out_valid / out_stall. A pixel is
// delivered at a rising edge where out_valid is high and out_stall is low.
// All values are unsigned COMPONENT_BITS fractions; hue is a fraction of a turn.
// A pixel passes through six register stages, the last one being the output
// register. Throughput: one pixel per clock while no output stall holds the
// pipe; the l*s and chroma*fraction multipliers sit in stages of their own,
// apart from the rounding divide and the channel select.
// Stall: the whole pipe moves on a common enable. While the output holds a
// pixel that is stalled, every stage holds and in_stall is raised; nothing is
// dropped or repeated. An empty output register lets the pipe move regardless.
// Reset (rst, synchronous, active high) clears all valid bits; the block keeps
// no other state between pixels.
module hsl_to_rgb_converter #(
  parameter int COMPONENT_BITS = hsl2rgb_pkg::COMPONENT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COMPONENT_BITS-1:0] hue,
  input  logic [COMPONENT_BITS-1:0] saturation,
  input  logic [COMPONENT_BITS-1:0] lightness,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COMPONENT_BITS-1:0] red,
  output logic [COMPONENT_BITS-1:0] green,
  output logic [COMPONENT_BITS-1:0] blue
);
  import hsl2rgb_pkg::*;

  localparam int B = COMPONENT_BITS;
  localparam logic [B:0]     FULL_X = {1'b0, {B{1'b1}}};
  localparam logic [2*B-1:0] HALF_W = {{B{1'b0}}, 1'b1, {(B-1){1'b0}}};
  localparam logic [2*B-1:0] ONE_W  = {{(2*B-1){1'b0}}, 1'b1};

  logic adv;

  // stage a: input registers
  logic         a_valid;
  logic [B-1:0] a_h, a_s, a_l;
  // stage b: products
  logic           b_valid;
  logic [2*B-1:0] b_ls;
  logic [B+2:0]   b_h6;
  logic [B-1:0]   b_s, b_l;
  // stage c: rounded l*s
  logic         c_valid;
  logic [B-1:0] c_p, c_s, c_l;
  logic [B+2:0] c_h6;
  // stage d: chroma top and floor
  logic         d_valid, d_gray;
  logic [B-1:0] d_v, d_m, d_l, d_fract;
  logic [2:0]   d_sext;
  // stage e: ramp product
  logic           e_valid, e_gray;
  logic [2*B-1:0] e_prod;
  logic [B-1:0]   e_v, e_m, e_l;
  logic [2:0]     e_sext;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage c logic: divide by 2^B-1 via x + (x >> B) + 1, exact over this range
  logic [2*B-1:0] c_x, c_q;
  assign c_x = b_ls + HALF_W;
  assign c_q = c_x + (c_x >> B) + ONE_W;

  // stage d logic
  logic [B:0] d_vraw, d_vclip, d_ls_sum, d_l2, d_mraw, d_p_x;
  always_comb begin
    d_p_x    = {1'b0, c_p};
    d_ls_sum = {1'b0, c_l} + {1'b0, c_s};
    if (!c_l[B-1]) begin
      d_vraw = {1'b0, c_l} + d_p_x;
    end else if (d_ls_sum >= d_p_x) begin
      d_vraw = d_ls_sum - d_p_x;
    end else begin
      d_vraw = '0;
    end
    d_vclip = (d_vraw > FULL_X) ? FULL_X : d_vraw;
    d_l2    = {c_l, 1'b0};
    d_mraw  = (d_l2 > d_vclip) ? (d_l2 - d_vclip) : '0;
  end

  // stage e logic
  logic [B-1:0] e_diff;
  assign e_diff = (d_v >= d_m) ? (d_v - d_m) : '0;

  // output stage logic
  logic [2*B-1:0] f_rnd;
  logic [B-1:0]   f_vsf;
  logic [B:0]     f_mid1, f_mid2, f_v, f_m, f_r, f_g, f_b;
  always_comb begin
    f_rnd  = e_prod + HALF_W;
    f_vsf  = f_rnd[2*B-1:B];
    f_v    = {1'b0, e_v};
    f_m    = {1'b0, e_m};
    f_mid1 = f_m + {1'b0, f_vsf};
    f_mid2 = (e_v >= f_vsf) ? (f_v - {1'b0, f_vsf}) : '0;
    unique case (sextant_t'(e_sext))
      SEXT_RED_YEL: begin f_r = f_v;    f_g = f_mid1; f_b = f_m;    end
      SEXT_YEL_GRN: begin f_r = f_mid2; f_g = f_v;    f_b = f_m;    end
      SEXT_GRN_CYN: begin f_r = f_m;    f_g = f_v;    f_b = f_mid1; end
      SEXT_CYN_BLU: begin f_r = f_m;    f_g = f_mid2; f_b = f_v;    end
      SEXT_BLU_MAG: begin f_r = f_mid1; f_g = f_m;    f_b = f_v;    end
      default:      begin f_r = f_v;    f_g = f_m;    f_b = f_mid2; end
    endcase
    if (e_gray) begin
      f_r = {1'b0, e_l};
      f_g = {1'b0, e_l};
      f_b = {1'b0, e_l};
    end
    f_r = (f_r > FULL_X) ? FULL_X : f_r;
    f_g = (f_g > FULL_X) ? FULL_X : f_g;
    f_b = (f_b > FULL_X) ? FULL_X : f_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_h <= hue;
      a_s <= saturation;
      a_l <= lightness;

      b_ls <= {{B{1'b0}}, a_l} * {{B{1'b0}}, a_s};
      b_h6 <= {3'b000, a_h} * (B+3)'(6);
      b_s  <= a_s;
      b_l  <= a_l;

      c_p  <= c_q[2*B-1:B];
      c_s  <= b_s;
      c_l  <= b_l;
      c_h6 <= b_h6;

      d_v     <= d_vclip[B-1:0];
      d_m     <= d_mraw[B-1:0];
      d_gray  <= (d_vclip == '0);
      d_l     <= c_l;
      d_sext  <= c_h6[B+2:B];
      d_fract <= c_h6[B-1:0];

      e_prod <= {{B{1'b0}}, e_diff} * {{B{1'b0}}, d_fract};
      e_v    <= d_v;
      e_m    <= d_m;
      e_l    <= d_l;
      e_gray <= d_gray;
      e_sext <= d_sext;

      red   <= f_r[B-1:0];
      green <= f_g[B-1:0];
      blue  <= f_b[B-1:0];
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import hsl2rgb_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int N_DIR = 22;
  localparam int RAND_PER_PHASE = 275;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] light;
    logic          typed;
    rgb_t          px;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CB-1:0] hue = '0;
  logic [CB-1:0] saturation = '0;
  logic [CB-1:0] lightness = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  rgb_t pending_rgb [$];
  int   mismatch_cnt = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  // typed rows are plain gray, white or pure red cases
  stim_row_t dir_rows [0:N_DIR-1] = '{
    '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{16'd65535, 16'd65535, 16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{16'd21845, 16'd0,     16'd32767, 1'b1, '{16'd32767, 16'd32767, 16'd32767}},
    '{16'd43690, 16'd0,     16'd65535, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
    '{16'd12345, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
    '{16'd0,     16'd65535, 16'd32767, 1'b1, '{16'd65534, 16'd0,     16'd0}},
    '{16'd10922, 16'd65535, 16'd32767, 1'b0, '0},
    '{16'd10923, 16'd65535, 16'd32767, 1'b0, '0},
    '{16'd21845, 16'd65535, 16'd32768, 1'b0, '0},
    '{16'd21846, 16'd50000, 16'd20000, 1'b0, '0},
    '{16'd32767, 16'd40000, 16'd45000, 1'b0, '0},
    '{16'd32768, 16'd65535, 16'd32768, 1'b0, '0},
    '{16'd43690, 16'd30000, 16'd10000, 1'b0, '0},
    '{16'd43691, 16'd65535, 16'd60000, 1'b0, '0},
    '{16'd54613, 16'd1,     16'd1,     1'b0, '0},
    '{16'd54614, 16'd65535, 16'd65534, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'd32767, 1'b0, '0},
    '{16'd65535, 16'd1,     16'd65534, 1'b0, '0},
    '{16'd5000,  16'd65534, 16'd32767, 1'b0, '0},
    '{16'd60000, 16'd12345, 16'd54321, 1'b0, '0},
    '{16'd27000, 16'd65535, 16'd1,     1'b0, '0},
    '{16'd38000, 16'd32768, 16'd32768, 1'b0, '0}
  };

  hsl_to_rgb_converter u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned sat_channel(input longint unsigned x);
    longint unsigned full;
    full = (64'd1 << CB) - 1;
    return (x > full) ? full : x;
  endfunction

  function automatic rgb_t hsl_pixel_to_rgb(input logic [CB-1:0] h, s, l);
    longint unsigned full, half, hw, sw, lw, ls_prod, top, bot, h6, frac, ramp;
    longint unsigned rise, fall, r, g, b;
    sextant_t sx;
    rgb_t px;
    full = (64'd1 << CB) - 1;
    half = 64'd1 << (CB - 1);
    hw = 64'(h);
    sw = 64'(s);
    lw = 64'(l);
    ls_prod = (lw * sw + half) / full;
    if (2 * lw <= full) begin
      top = lw + ls_prod;
    end else begin
      top = (lw + sw >= ls_prod) ? (lw + sw - ls_prod) : 0;
    end
    top = sat_channel(top);
    r = lw;
    g = lw;
    b = lw;
    // zero chroma top leaves the pixel gray
    if (top != 0) begin
      bot = (2 * lw > top) ? (2 * lw - top) : 0;
      h6 = hw * 6;
      sx = sextant_t'(h6 >> CB);
      frac = h6 & full;
      ramp = (top >= bot) ? (((top - bot) * frac + half) >> CB) : 0;
      rise = bot + ramp;
      fall = (top >= ramp) ? (top - ramp) : 0;
      case (sx)
        SEXT_RED_YEL: begin r = top;  g = rise; b = bot;  end
        SEXT_YEL_GRN: begin r = fall; g = top;  b = bot;  end
        SEXT_GRN_CYN: begin r = bot;  g = top;  b = rise; end
        SEXT_CYN_BLU: begin r = bot;  g = fall; b = top;  end
        SEXT_BLU_MAG: begin r = rise; g = bot;  b = top;  end
        default:      begin r = top;  g = bot;  b = fall; end
      endcase
    end
    px.red   = CB'(sat_channel(r));
    px.green = CB'(sat_channel(g));
    px.blue  = CB'(sat_channel(b));
    return px;
  endfunction

  // biased towards the ends of the range and the half-way point
  function automatic logic [CB-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CB'((1 << (CB - 1)) - 2 + $urandom_range(3));
      3:       return CB'($urandom_range(3));
      4:       return CB'((1 << CB) - 1 - $urandom_range(3));
      default: return CB'($urandom);
    endcase
  endfunction

  // called and left at a falling edge
  task automatic send_pixel(input logic [CB-1:0] h, s, l, input logic typed, input rgb_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    lightness  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rgb.push_back(typed ? px : hsl_pixel_to_rgb(h, s, l));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, red, green, blue);
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red || green !== want.green || blue !== want.blue) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue, red, green, blue);
        end
      end
    end
  end

  initial begin
    int phase_idle [4] = '{0, 47, 0, 12};
    int phase_stall [4] = '{0, 0, 47, 12};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].light,
                 dir_rows[i].typed, dir_rows[i].px);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (RAND_PER_PHASE)
        send_pixel(($urandom_range(3) == 0) ? pick_level() : CB'($urandom),
                   pick_level(), pick_level(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    // let any stalled requests drain before looking for stray output
    stall_pct = 0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rgb.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
